[design/nearest_colour_window_search_assert.svh]
// assertion macros for the nearest colour window search block
// used by nearest_colour_window_search.sv, expects clk and rst_n in scope
`ifndef NEAREST_COLOUR_WINDOW_SEARCH_ASSERT_SVH
`define NEAREST_COLOUR_WINDOW_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define NCWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NCWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NCWS_ASSERT(label, prop, msg)
`define NCWS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[design/ncws_pkg.sv]
// package for the nearest colour window search block
// widths, register indexes and the colour distance helper; no dependencies
package ncws_pkg;

  localparam int COORD_W     = 11;
  localparam int COLOR_W     = 8;
  localparam int DIST_W      = 18;
  localparam int SQ_W        = 2 * COLOR_W;
  localparam int RANK_W      = 15;
  localparam int RING_W      = 6;
  localparam int RINGS_W     = 7;
  localparam int OFF_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [RINGS_W-1:0] MAX_RINGS   = 7'd64;
  localparam logic [RINGS_W-1:0] RINGS_RESET = 7'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_RED   = 3'd0,
    REG_TARGET_GREEN = 3'd1,
    REG_TARGET_BLUE  = 3'd2,
    REG_CENTER_X     = 3'd3,
    REG_CENTER_Y     = 3'd4,
    REG_WINDOW_RINGS = 3'd5
  } cfg_reg_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

[design/nearest_colour_window_search.sv]
// nearest colour search over square rings around a centre, pixel stream in
// the result is registered: the last pixel passes the input register and stage b before the result register loads
// throughput: one pixel per cycle while not stalled; input register, ring/distance stage, update stage
// the pipeline stalls only when a frame's last pixel meets a result not yet taken
// reset (rst_n low, synchronous) empties the pipeline, clears the search state
// and sets targets and centre to 0 and the ring count to 50
`include "nearest_colour_window_search_assert.svh"

module nearest_colour_window_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ncws_pkg::COORD_W-1:0]       in_pixel_x,
  input  logic [ncws_pkg::COORD_W-1:0]       in_pixel_y,
  input  logic [ncws_pkg::COLOR_W-1:0]       in_pixel_red,
  input  logic [ncws_pkg::COLOR_W-1:0]       in_pixel_green,
  input  logic [ncws_pkg::COLOR_W-1:0]       in_pixel_blue,
  input  logic                               in_last_pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ncws_pkg::COORD_W-1:0]       out_found_x,
  output logic [ncws_pkg::COORD_W-1:0]       out_found_y,
  output logic                               out_found,
  output logic [ncws_pkg::DIST_W-1:0]        out_best_distance_sq,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ncws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ncws_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ncws_pkg::*;

  // configuration registers
  logic [COLOR_W-1:0] target_red_r, target_green_r, target_blue_r;
  logic [COORD_W-1:0] center_x_r, center_y_r;
  logic [RINGS_W-1:0] window_rings_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_red_r   <= '0;
      target_green_r <= '0;
      target_blue_r  <= '0;
      center_x_r     <= '0;
      center_y_r     <= '0;
      window_rings_r <= RINGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_RED:   target_red_r   <= cfg_data[COLOR_W-1:0];
        REG_TARGET_GREEN: target_green_r <= cfg_data[COLOR_W-1:0];
        REG_TARGET_BLUE:  target_blue_r  <= cfg_data[COLOR_W-1:0];
        REG_CENTER_X:     center_x_r     <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:     center_y_r     <= cfg_data[COORD_W-1:0];
        REG_WINDOW_RINGS: window_rings_r <= cfg_data[RINGS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_valid_r, b_valid_r, out_valid_r;
  logic b_last_r;
  logic b_retire, b_ready, a_move, in_take;

  assign b_retire = b_valid_r && !(b_last_r && out_valid_r && !out_ready);
  assign b_ready  = !b_valid_r || b_retire;
  assign a_move   = a_valid_r && b_ready;
  assign in_ready = !a_valid_r || b_ready;
  assign in_take  = in_valid && in_ready;

  // stage a: input register
  logic [COORD_W-1:0] a_x_r, a_y_r;
  logic [COLOR_W-1:0] a_red_r, a_green_r, a_blue_r;
  logic               a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_x_r     <= in_pixel_x;
      a_y_r     <= in_pixel_y;
      a_red_r   <= in_pixel_red;
      a_green_r <= in_pixel_green;
      a_blue_r  <= in_pixel_blue;
      a_last_r  <= in_last_pixel;
    end
  end

  // ring membership and scan rank
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0]        adx, ady, ring_i;
  logic [RINGS_W-1:0]        rings_eff;
  logic                      on_top, on_bottom, on_right, in_win, searched;
  logic [RING_W-1:0]         i6;
  logic signed [OFF_W-1:0]   i_s, dx_s, dy_s, i_x3, i_x4, i_x5, i_x7, off;
  logic [2*RING_W-1:0]       i_prod;
  logic [RANK_W-1:0]         rank;
  logic [DIST_W-1:0]         colour_dist;

  always_comb begin
    dx  = $signed({1'b0, a_x_r}) - $signed({1'b0, center_x_r});
    dy  = $signed({1'b0, a_y_r}) - $signed({1'b0, center_y_r});
    adx = dx[COORD_W] ? (~dx[COORD_W-1:0] + 1'b1) : dx[COORD_W-1:0];
    ady = dy[COORD_W] ? (~dy[COORD_W-1:0] + 1'b1) : dy[COORD_W-1:0];
    ring_i    = (adx > ady) ? adx : ady;
    rings_eff = (window_rings_r > MAX_RINGS) ? MAX_RINGS : window_rings_r;
    in_win    = (ring_i != '0) &&
                (ring_i < {{(COORD_W-RINGS_W){1'b0}}, rings_eff});
    on_top    = !dy[COORD_W] && (ady == ring_i);
    on_bottom =  dy[COORD_W] && (ady == ring_i);
    on_right  = !dx[COORD_W] && (adx == ring_i);
    // the (+i,+i) corner is skipped by the scan
    searched  = in_win && !(on_top && on_right);

    i6   = ring_i[RING_W-1:0];
    i_s  = $signed({{(OFF_W-RING_W){1'b0}}, i6});
    dx_s = dx[OFF_W-1:0];
    dy_s = dy[OFF_W-1:0];
    i_x3 = (i_s <<< 1) + i_s;
    i_x4 = i_s <<< 2;
    i_x5 = i_x4 + i_s;
    i_x7 = (i_s <<< 3) - i_s;
    if (on_top) begin
      off = dx_s + i_s;
    end else if (on_bottom) begin
      off = (dx_s < i_s) ? (i_x3 + dx_s) : i_x4;
    end else if (on_right) begin
      off = i_x5 + dy_s;
    end else begin
      off = i_x7 + dy_s;
    end
    i_prod = {{RING_W{1'b0}}, i6} * ({{RING_W{1'b0}}, i6} - (2*RING_W)'(1));
    rank   = RANK_W'({i_prod, 2'b00}) + RANK_W'(off[OFF_W-2:0]);

    colour_dist = DIST_W'(sq_diff(a_red_r, target_red_r)) +
                  DIST_W'(sq_diff(a_green_r, target_green_r)) +
                  DIST_W'(sq_diff(a_blue_r, target_blue_r));
  end

  // stage b: ranked candidate
  logic               b_searched_r;
  logic [COORD_W-1:0] b_x_r, b_y_r;
  logic [DIST_W-1:0]  b_dist_r;
  logic [RANK_W-1:0]  b_rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_move) begin
      b_valid_r <= 1'b1;
    end else if (b_retire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_searched_r <= searched;
      b_last_r     <= a_last_r;
      b_x_r        <= a_x_r;
      b_y_r        <= a_y_r;
      b_dist_r     <= colour_dist;
      b_rank_r     <= rank;
    end
  end

  // best-so-far state and the compare
  logic               have_best_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [RANK_W-1:0]  best_rank_r;
  logic [COORD_W-1:0] best_col_r, best_row_r;
  logic               better, take, m_have;
  logic [DIST_W-1:0]  m_dist;
  logic [COORD_W-1:0] m_col, m_row;

  always_comb begin
    better = !have_best_r || (b_dist_r < best_dist_r) ||
             ((b_dist_r == best_dist_r) && (b_rank_r < best_rank_r));
    take   = b_searched_r && better;
    m_have = have_best_r || b_searched_r;
    m_dist = take ? b_dist_r : best_dist_r;
    m_col  = take ? b_x_r : best_col_r;
    m_row  = take ? b_y_r : best_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      best_dist_r <= '0;
      best_rank_r <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
    end else if (b_retire) begin
      if (b_last_r) begin
        // frame done, start over
        have_best_r <= 1'b0;
        best_dist_r <= '0;
        best_rank_r <= '0;
        best_col_r  <= '0;
        best_row_r  <= '0;
      end else if (take) begin
        have_best_r <= 1'b1;
        best_dist_r <= b_dist_r;
        best_rank_r <= b_rank_r;
        best_col_r  <= b_x_r;
        best_row_r  <= b_y_r;
      end
    end
  end

  // result register
  logic               out_found_r;
  logic [COORD_W-1:0] out_found_x_r, out_found_y_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_load;

  assign out_load = b_retire && b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r   <= m_have;
      out_found_x_r <= m_have ? m_col : '0;
      out_found_y_r <= m_have ? m_row : '0;
      out_dist_r    <= m_have ? m_dist : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_found_x          = out_found_x_r;
  assign out_found_y          = out_found_y_r;
  assign out_best_distance_sq = out_dist_r;

  `NCWS_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !a_valid_r && !b_valid_r, "pipeline not empty after reset")
  `NCWS_ASSERT(a_stall_only_on_last, b_valid_r && !b_retire |-> b_last_r && out_valid_r, "update stage stalled without a pending result")
  `NCWS_ASSERT(a_clear_after_frame, out_load |=> !have_best_r && out_valid_r, "search state not cleared after a frame")
  `NCWS_ASSERT(a_empty_result_zero, out_valid_r && !out_found_r |-> out_found_x_r == '0 && out_found_y_r == '0 && out_dist_r == '0, "empty result carries nonzero fields")

endmodule

[verif/tb.sv]
// testbench for nearest_colour_window_search: directed and random pixel frames
// depends on ncws_pkg and the block's rtl; self-checking against an in-bench predictor
`timescale 1ns / 1ps

module tb;
  import ncws_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               found;
    logic [DIST_W-1:0]  dist_sq;
  } match_t;

  localparam int PIXEL_W = $bits(pixel_t);

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [COORD_W-1:0]    in_pixel_x;
  logic [COORD_W-1:0]    in_pixel_y;
  logic [COLOR_W-1:0]    in_pixel_red;
  logic [COLOR_W-1:0]    in_pixel_green;
  logic [COLOR_W-1:0]    in_pixel_blue;
  logic                  in_last_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [COORD_W-1:0]    out_found_x;
  logic [COORD_W-1:0]    out_found_y;
  logic                  out_found;
  logic [DIST_W-1:0]     out_best_distance_sq;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nearest_colour_window_search dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_pixel_x           (in_pixel_x),
    .in_pixel_y           (in_pixel_y),
    .in_pixel_red         (in_pixel_red),
    .in_pixel_green       (in_pixel_green),
    .in_pixel_blue        (in_pixel_blue),
    .in_last_pixel        (in_last_pixel),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_found_x          (out_found_x),
    .out_found_y          (out_found_y),
    .out_found            (out_found),
    .out_best_distance_sq (out_best_distance_sq),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // predictor copy of the registers and the running search
  logic [COLOR_W-1:0] tgt_red = '0;
  logic [COLOR_W-1:0] tgt_green = '0;
  logic [COLOR_W-1:0] tgt_blue = '0;
  logic [COORD_W-1:0] ctr_x = '0;
  logic [COORD_W-1:0] ctr_y = '0;
  logic [RINGS_W-1:0] ring_count = RINGS_RESET;

  int                 nearest_dist = 0;
  int                 nearest_rank = 0;
  logic [COORD_W-1:0] nearest_x = '0;
  logic [COORD_W-1:0] nearest_y = '0;
  bit                 have_nearest = 0;

  match_t expected_matches[$];

  bit sender_gaps = 1;
  bit receiver_gaps = 1;
  int sink_hold_cycles = 0;
  int error_count = 0;
  int pixels_sent = 0;
  int matches_checked = 0;
  int reg_writes = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still outstanding", expected_matches.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int colour_dist_sq(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    int d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d * d;
  endfunction

  // position in the ring scan; 0 when the pixel is outside the searched rings or on the skipped corner
  function automatic bit ring_scan_rank(input int dx, input int dy, input int rings,
                                        output int rank);
    int ax, ay, ring, off;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    ring = (ax > ay) ? ax : ay;
    rank = 0;
    if (ring < 1 || ring >= rings) return 0;
    if (dy == ring) begin
      if (dx == ring) return 0;
      off = dx + ring;
    end else if (dy == -ring) begin
      off = (dx < ring) ? 3 * ring + dx : 4 * ring;
    end else if (dx == ring) begin
      off = 5 * ring + dy;
    end else begin
      off = 7 * ring + dy;
    end
    rank = 4 * ring * (ring - 1) + off;
    return 1;
  endfunction

  function automatic int active_rings();
    return (ring_count > MAX_RINGS) ? int'(MAX_RINGS) : int'(ring_count);
  endfunction

  function automatic void predict_pixel(pixel_t p);
    int     rank, d;
    match_t m;
    if (ring_scan_rank(int'(p.x) - int'(ctr_x), int'(p.y) - int'(ctr_y),
                       active_rings(), rank)) begin
      d = colour_dist_sq(p.red, tgt_red) + colour_dist_sq(p.green, tgt_green) +
          colour_dist_sq(p.blue, tgt_blue);
      if (!have_nearest || d < nearest_dist || (d == nearest_dist && rank < nearest_rank)) begin
        nearest_dist = d;
        nearest_rank = rank;
        nearest_x = p.x;
        nearest_y = p.y;
        have_nearest = 1;
      end
    end
    if (p.last) begin
      m.x = have_nearest ? nearest_x : '0;
      m.y = have_nearest ? nearest_y : '0;
      m.found = have_nearest;
      m.dist_sq = have_nearest ? DIST_W'(nearest_dist) : '0;
      expected_matches = {expected_matches, m};
      nearest_dist = 0;
      nearest_rank = 0;
      nearest_x = '0;
      nearest_y = '0;
      have_nearest = 0;
    end
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void check_match();
    match_t want;
    if (expected_matches.size() == 0) begin
      note_failure($sformatf("result with nothing expected: x=%0d y=%0d found=%0d d=%0d",
                             out_found_x, out_found_y, out_found, out_best_distance_sq));
      return;
    end
    want = expected_matches.pop_front();
    matches_checked++;
    if (out_found_x !== want.x || out_found_y !== want.y || out_found !== want.found ||
        out_best_distance_sq !== want.dist_sq)
      note_failure($sformatf("exp x=%0d y=%0d found=%0d d=%0d, got x=%0d y=%0d found=%0d d=%0d",
                             want.x, want.y, want.found, want.dist_sq, out_found_x,
                             out_found_y, out_found, out_best_distance_sq));
  endfunction

  // result sink: random stall before each transaction, plus requested long hold-offs
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        check_match();
        wait_left = receiver_gaps ? $urandom_range(0, 3) : 0;
      end
      if (sink_hold_cycles > 0) begin
        wait_left = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid is only lowered when a gap is drawn, so back-to-back pixels keep it high
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_x     <= p.x;
    in_pixel_y     <= p.y;
    in_pixel_red   <= p.red;
    in_pixel_green <= p.green;
    in_pixel_blue  <= p.blue;
    in_last_pixel  <= p.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(p);
    pixels_sent++;
  endtask

  task automatic send(int x, int y, int r, int g, int b, bit last);
    pixel_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.red = COLOR_W'(r);
    p.green = COLOR_W'(g);
    p.blue = COLOR_W'(b);
    p.last = last;
    send_pixel(p);
  endtask

  // stop offering pixels and let the pipeline empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET_RED:   tgt_red = val[COLOR_W-1:0];
      REG_TARGET_GREEN: tgt_green = val[COLOR_W-1:0];
      REG_TARGET_BLUE:  tgt_blue = val[COLOR_W-1:0];
      REG_CENTER_X:     ctr_x = val[COORD_W-1:0];
      REG_CENTER_Y:     ctr_y = val[COORD_W-1:0];
      REG_WINDOW_RINGS: ring_count = val[RINGS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reset values: 50 rings around (0,0), black target
  task automatic test_default_window();
    send(0, 0, 0, 0, 0, 0);           // centre is ring 0, never searched
    send(1, 1, 0, 0, 0, 0);           // skipped corner of ring 1
    send(50, 3, 0, 0, 0, 0);          // just outside the window
    send(49, 10, 255, 255, 255, 0);   // worst possible distance, but the only candidate
    send(2047, 2047, 0, 0, 0, 0);
    send(0, 0, 0, 0, 0, 1);
    drain_pipeline();
  endtask

  task automatic test_no_rings();
    write_reg(REG_WINDOW_RINGS, 11'd1);
    send(1, 0, 0, 0, 0, 1);
    drain_pipeline();
    write_reg(REG_WINDOW_RINGS, 11'd0);
    send(0, 1, 7, 7, 7, 0);
    send(2047, 0, 0, 0, 0, 1);
    drain_pipeline();
  endtask

  // equal distances settle by scan order: ring, then side, then position
  task automatic test_tie_order();
    write_reg(REG_CENTER_X, 11'd1000);
    write_reg(REG_CENTER_Y, 11'd1000);
    write_reg(REG_WINDOW_RINGS, 11'd3);
    write_reg(REG_TARGET_RED, 11'd128);
    write_reg(REG_TARGET_GREEN, 11'd64);
    write_reg(REG_TARGET_BLUE, 11'd200);
    send(998, 1001, 128, 64, 200, 0);
    send(1002, 999, 128, 64, 200, 0);
    send(999, 998, 128, 64, 200, 0);
    send(1002, 998, 128, 64, 200, 0);
    send(998, 1002, 128, 64, 200, 0);
    send(998, 1002, 128, 64, 200, 0);  // repeated position
    send(1000, 1001, 129, 64, 200, 0);
    send(1000, 999, 128, 64, 200, 1);
    drain_pipeline();
    send(1001, 1001, 128, 64, 200, 0);
    send(999, 999, 130, 65, 200, 0);
    send(1003, 1000, 128, 64, 200, 1);
    drain_pipeline();
  endtask

  // ring count above the maximum, window hanging over the frame corner
  task automatic test_ring_limit();
    write_reg(REG_CENTER_X, 11'd2047);
    write_reg(REG_CENTER_Y, 11'd0);
    write_reg(REG_WINDOW_RINGS, 11'd127);
    write_reg(REG_TARGET_RED, 11'd255);
    write_reg(REG_TARGET_GREEN, 11'd255);
    write_reg(REG_TARGET_BLUE, 11'd255);
    send(1984, 0, 0, 0, 0, 0);
    send(1983, 5, 255, 255, 255, 0);
    send(2047, 63, 250, 255, 255, 1);
    drain_pipeline();
  endtask

  // target changes between two pixels of one frame
  task automatic test_midframe_write();
    write_reg(REG_TARGET_RED, 11'd0);
    write_reg(REG_TARGET_GREEN, 11'd0);
    write_reg(REG_TARGET_BLUE, 11'd0);
    send(2040, 3, 10, 0, 0, 0);
    drain_pipeline();
    write_reg(REG_TARGET_RED, 11'd10);
    send(2045, 2, 10, 0, 0, 1);
    drain_pipeline();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_colour_setting();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0: v[COLOR_W-1:0] = '0;
      1: v[COLOR_W-1:0] = '1;
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) v[CFG_DATA_W-1:COLOR_W] = '0;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_centre_setting();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 11'd1000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rings_setting();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 11'd0;
      1: v = 11'd1;
      2: v = 11'd2;
      3: v = 11'd64;
      4: v = CFG_DATA_W'($urandom_range(65, 127));
      default: v = CFG_DATA_W'($urandom_range(2, 64));
    endcase
    if ($urandom_range(0, 3) == 0)
      v[CFG_DATA_W-1:RINGS_W] = (CFG_DATA_W-RINGS_W)'($urandom);
    return v;
  endfunction

  task automatic shuffle_settings();
    if ($urandom_range(0, 9) < 7) write_reg(REG_TARGET_RED, pick_colour_setting());
    if ($urandom_range(0, 9) < 7) write_reg(REG_TARGET_GREEN, pick_colour_setting());
    if ($urandom_range(0, 9) < 7) write_reg(REG_TARGET_BLUE, pick_colour_setting());
    if ($urandom_range(0, 9) < 7) write_reg(REG_CENTER_X, pick_centre_setting());
    if ($urandom_range(0, 9) < 7) write_reg(REG_CENTER_Y, pick_centre_setting());
    if ($urandom_range(0, 9) < 5) write_reg(REG_WINDOW_RINGS, pick_rings_setting());
  endtask

  function automatic logic [COLOR_W-1:0] near_channel(logic [COLOR_W-1:0] t);
    return (COLOR_W)'(int'(t) + int'($urandom_range(0, 2)) - 1);
  endfunction

  // mostly pixels in or near the window, half with colours close to the target, some noise
  function automatic pixel_t make_pixel(pixel_t prev, bit has_prev);
    pixel_t p;
    int     span, sel;
    span = (active_rings() < 1) ? 1 : active_rings();
    sel = $urandom_range(0, 19);
    p = PIXEL_W'({$urandom, $urandom});
    if (has_prev && sel < 2) begin
      p = prev;
    end else if (sel < 16) begin
      p.x = (COORD_W)'(int'(ctr_x) + int'($urandom_range(0, 2 * span)) - span);
      p.y = (COORD_W)'(int'(ctr_y) + int'($urandom_range(0, 2 * span)) - span);
    end
    if ($urandom_range(0, 1) == 0) begin
      p.red = near_channel(tgt_red);
      p.green = near_channel(tgt_green);
      p.blue = near_channel(tgt_blue);
    end
    p.last = 1'b0;
    return p;
  endfunction

  task automatic test_random_frames(int budget);
    pixel_t p;
    int     stop_at, frame_len, frames_left;
    stop_at = pixels_sent + budget;
    frames_left = 0;
    while (pixels_sent < stop_at) begin
      if (frames_left == 0) begin
        drain_pipeline();
        shuffle_settings();
        frames_left = $urandom_range(1, 6);
      end
      frames_left--;
      sender_gaps = ($urandom_range(0, 4) != 0);
      receiver_gaps = ($urandom_range(0, 4) != 0);
      frame_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      for (int i = 0; i < frame_len; i++) begin
        p = make_pixel(p, i > 0);
        p.last = (i == frame_len - 1);
        send_pixel(p);
      end
    end
    drain_pipeline();
    sender_gaps = 1;
    receiver_gaps = 1;
  endtask

  // long receiver hold while short frames keep coming, then a full sender pause
  task automatic test_output_backpressure();
    pixel_t p;
    sender_gaps = 0;
    sink_hold_cycles = 200;
    for (int i = 0; i < 30; i++) begin
      p = make_pixel(p, 0);
      p.last = (i % 2 == 1) || ($urandom_range(0, 1) == 0);
      send_pixel(p);
    end
    p = make_pixel(p, 0);
    p.last = 1'b1;
    send_pixel(p);
    drain_pipeline();
    for (int i = 0; i < 6; i++) begin
      p = make_pixel(p, 0);
      p.last = 1'b1;
      send_pixel(p);
    end
    drain_pipeline();
    sender_gaps = 1;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_x     <= '0;
    in_pixel_y     <= '0;
    in_pixel_red   <= '0;
    in_pixel_green <= '0;
    in_pixel_blue  <= '0;
    in_last_pixel  <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_TARGET_RED;
    cfg_data       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_no_rings();
    test_tie_order();
    test_ring_limit();
    test_midframe_write();
    test_output_backpressure();
    test_random_frames(1840);

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (expected_matches.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_matches.size()));
    $display("sent %0d pixels, checked %0d frame results, %0d register writes",
             pixels_sent, matches_checked, reg_writes);
    $display("covered ties, skipped corners, ring limits, edge windows and output stalls");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
